FILE: design/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the time-lapse slider sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int unsigned NOW_W   = 32;
   localparam int unsigned OP_W    = 2;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned POWER_W = 8;
   localparam int unsigned LED2_W  = 2;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned REQ_W   = 40;
   localparam int unsigned RSP_W   = 32;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned CSR_A_W = 2;

   localparam logic [NOW_W-1:0] SETTLE_MS = 32'd500;
   localparam logic [NOW_W-1:0] SHOOT_MS  = 32'd50;
   localparam logic [NOW_W-1:0] PAUSE_MS  = 32'd300;

   localparam logic [POWER_W-1:0] POWER_OFF   = 8'd0;
   localparam logic [POWER_W-1:0] POWER_CREEP = 8'd100;
   localparam logic [POWER_W-1:0] POWER_FAST  = 8'd255;

   localparam logic [LED2_W-1:0] LED2_OFF   = 2'd0;
   localparam logic [LED2_W-1:0] LED2_ON    = 2'd1;
   localparam logic [LED2_W-1:0] LED2_BLINK = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_NONE  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_HOME  = 2'd3
   } op_type;

   typedef enum logic [MODE_W-1:0] {
      RM_IDLE     = 3'd0,
      RM_START    = 3'd1,
      RM_STOP     = 3'd2,
      RM_HOME_REQ = 3'd3,
      RM_RUNNING  = 3'd4,
      RM_HOMING   = 3'd5
   } run_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_FORWARD  = 3'd1,
      ST_SETTLE   = 3'd2,
      ST_SHOOT    = 3'd3,
      ST_WAIT     = 3'd4,
      ST_BACKWARD = 3'd5
   } step_type;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_MOVE_SPEED  = 2'd0,
      CSR_EXPOSURE    = 2'd1,
      CSR_TOTAL       = 2'd2,
      CSR_FORWARD_DIR = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [NOW_W-1:0]   move_span;
      logic [NOW_W-1:0]   exposure_wait_ms;
      logic [COUNT_W-1:0] total_photos;
      logic               forward_direction;
   } cfg_type;

   typedef struct packed {
      logic [NOW_W-1:0]  now_ms;
      logic [OP_W-1:0]   op;
      logic              emergency_stop;
      logic              at_end;
   } poll_type;

   typedef struct packed {
      run_mode_type       run_mode;
      step_type           step_mode;
      logic [NOW_W-1:0]   time_mark;
      logic [COUNT_W-1:0] photo_count;
      logic [POWER_W-1:0] motor_power;
      logic               motor_dir;
      logic               shutter_on;
      logic               led1_mode;
      logic [LED2_W-1:0]  led2_mode;
   } seq_state_type;

endpackage

FILE: design/timelapse_slider_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timelapse_slider_sequencer_core
// Time-lapse slider sequencer: one poll in, one status item out.
// ----------------------------------------------------------------------------
// Each poll item is registered on entry and then processed by the next-state
// logic, whose result lands in the sequencer state registers that also form
// the result item. A poll passes the poll register and then the state
// registers before its result is shown, and a new poll is accepted every cycle
// while results are taken; the rate is set by the single state update per
// poll. The forward travel span is scaled by SPEED_SCALE when move_speed is
// written, so no multiplier sits in the poll path.
module timelapse_slider_sequencer_core #(
   parameter int unsigned SPEED_SCALE = 100
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // now_ms[31:0], op[33:32], emergency_stop[34], at_end[35], zero[39:36]
   input  logic [tss_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // motor_power[7:0], motor_dir[8], shutter_on[9], led1_mode[10],
   // led2_mode[12:11], run_mode[15:13], photos_done[31:16]
   output logic [tss_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [tss_pkg::CSR_A_W-1:0]   csr_index,
   input  logic [tss_pkg::CSR_W-1:0]     csr_wdata
);
   import tss_pkg::*;

   localparam seq_state_type STATE_RESET = '{
      run_mode:    RM_IDLE,
      step_mode:   ST_IDLE,
      time_mark:   '0,
      photo_count: '0,
      motor_power: POWER_OFF,
      motor_dir:   1'b0,
      shutter_on:  1'b0,
      led1_mode:   1'b1,
      led2_mode:   LED2_OFF
   };

   cfg_type        cfg;
   poll_type       poll_ff;
   poll_type       poll_in;
   logic           poll_valid_ff;
   logic           poll_valid_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   seq_state_type  state_ff;
   seq_state_type  state_in;
   seq_state_type  state_next;
   logic           advance;
   logic           req_take;

   tss_csr #(
      .SPEED_SCALE (SPEED_SCALE)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tss_step u_step (
      .cfg  (cfg),
      .poll (poll_ff),
      .cur  (state_ff),
      .nxt  (state_next)
   );

   assign advance    = poll_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !poll_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      poll_in       = poll_ff;
      poll_valid_in = poll_valid_ff && !advance;
      if (req_take) begin
         poll_in.now_ms         = req_tdata[31:0];
         poll_in.op             = req_tdata[33:32];
         poll_in.emergency_stop = req_tdata[34];
         poll_in.at_end         = req_tdata[35];
         poll_valid_in          = 1'b1;
      end
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      state_in     = advance ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= STATE_RESET;
      end else begin
         poll_valid_ff <= poll_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      poll_ff <= poll_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {state_ff.photo_count, state_ff.run_mode, state_ff.led2_mode,
                        state_ff.led1_mode, state_ff.shutter_on, state_ff.motor_dir,
                        state_ff.motor_power};

endmodule

FILE: design/tss_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_csr
// Configuration registers; the forward travel span is scaled on write.
// ----------------------------------------------------------------------------
module tss_csr #(
   parameter int unsigned SPEED_SCALE = 100
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [tss_pkg::CSR_A_W-1:0]   csr_index,
   input  logic [tss_pkg::CSR_W-1:0]     csr_wdata,
   output tss_pkg::cfg_type              cfg
);
   import tss_pkg::*;

   localparam logic [15:0] SCALE = 16'(SPEED_SCALE);

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic [NOW_W-1:0]  span_calc;

   assign span_calc = {16'd0, csr_wdata[COUNT_W-1:0]} * {16'd0, SCALE};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MOVE_SPEED:  cfg_in.move_span         = span_calc;
            CSR_EXPOSURE:    cfg_in.exposure_wait_ms  = csr_wdata[NOW_W-1:0];
            CSR_TOTAL:       cfg_in.total_photos      = csr_wdata[COUNT_W-1:0];
            CSR_FORWARD_DIR: cfg_in.forward_direction = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/tss_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_step
// Next-state logic of the sequencer for one poll.
// ----------------------------------------------------------------------------
module tss_step (
   input  tss_pkg::cfg_type        cfg,
   input  tss_pkg::poll_type       poll,
   input  tss_pkg::seq_state_type  cur,
   output tss_pkg::seq_state_type  nxt
);
   import tss_pkg::*;

   logic [NOW_W-1:0]   elapsed;
   logic [COUNT_W-1:0] count_inc;
   run_mode_type       mode;

   assign elapsed   = poll.now_ms - cur.time_mark;
   assign count_inc = cur.photo_count + 1'b1;

   always_comb begin
      nxt  = cur;
      mode = cur.run_mode;
      if (op_type'(poll.op) != OP_NONE) begin
         mode = run_mode_type'({1'b0, poll.op});
      end
      if (poll.emergency_stop) begin
         mode = RM_STOP;
      end
      nxt.run_mode = mode;

      case (mode)
         RM_START, RM_STOP, RM_HOME_REQ: begin
            nxt.led1_mode   = 1'b0;
            nxt.led2_mode   = LED2_OFF;
            nxt.shutter_on  = 1'b0;
            nxt.motor_dir   = cfg.forward_direction;
            nxt.motor_power = POWER_OFF;
            nxt.step_mode   = ST_IDLE;
            if (mode == RM_START) begin
               nxt.photo_count = '0;
               nxt.run_mode    = RM_RUNNING;
            end else if (mode == RM_STOP) begin
               nxt.run_mode  = RM_IDLE;
               nxt.led1_mode = 1'b1;
            end else begin
               nxt.run_mode = RM_HOMING;
            end
         end
         RM_RUNNING: begin
            if (poll.at_end) begin
               nxt.run_mode = RM_STOP;
            end else begin
               case (cur.step_mode)
                  ST_FORWARD: begin
                     if (elapsed > cfg.move_span) begin
                        nxt.time_mark   = poll.now_ms;
                        nxt.motor_power = POWER_OFF;
                        nxt.led2_mode   = LED2_OFF;
                        nxt.step_mode   = ST_SETTLE;
                     end
                  end
                  ST_SETTLE: begin
                     if (elapsed > SETTLE_MS) begin
                        nxt.time_mark  = poll.now_ms;
                        nxt.shutter_on = 1'b1;
                        nxt.step_mode  = ST_SHOOT;
                     end
                  end
                  ST_SHOOT: begin
                     if (elapsed > SHOOT_MS) begin
                        nxt.time_mark   = poll.now_ms;
                        nxt.shutter_on  = 1'b0;
                        nxt.photo_count = count_inc;
                        nxt.step_mode   = ST_WAIT;
                     end
                  end
                  ST_WAIT: begin
                     if (elapsed > cfg.exposure_wait_ms) begin
                        nxt.time_mark   = poll.now_ms;
                        nxt.motor_power = POWER_CREEP;
                        nxt.led2_mode   = LED2_ON;
                        nxt.step_mode   = ST_FORWARD;
                        if (cur.photo_count == cfg.total_photos) begin
                           nxt.run_mode = RM_STOP;
                        end
                     end
                  end
                  ST_IDLE: begin
                     nxt.step_mode = ST_FORWARD;
                  end
                  default: begin
                     nxt.step_mode = cur.step_mode;
                  end
               endcase
            end
         end
         RM_HOMING: begin
            case (cur.step_mode)
               ST_IDLE: begin
                  if (poll.at_end) begin
                     nxt.run_mode = RM_STOP;
                  end else begin
                     nxt.led2_mode   = LED2_BLINK;
                     nxt.motor_dir   = ~cfg.forward_direction;
                     nxt.motor_power = POWER_FAST;
                     nxt.step_mode   = ST_BACKWARD;
                  end
               end
               ST_BACKWARD: begin
                  if (poll.at_end) begin
                     nxt.motor_power = POWER_OFF;
                     nxt.time_mark   = poll.now_ms;
                     nxt.step_mode   = ST_WAIT;
                  end
               end
               ST_WAIT: begin
                  if (elapsed > PAUSE_MS) begin
                     nxt.motor_dir   = cfg.forward_direction;
                     nxt.motor_power = POWER_CREEP;
                     nxt.step_mode   = ST_FORWARD;
                  end
               end
               ST_FORWARD: begin
                  if (!poll.at_end) begin
                     nxt.run_mode = RM_STOP;
                  end
               end
               default: begin
                  nxt.step_mode = cur.step_mode;
               end
            endcase
         end
         default: begin
            nxt.run_mode = mode;
         end
      endcase
   end

endmodule

FILE: bench/timelapse_slider_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timelapse_slider_sequencer_core_tb
// Self-checking bench for the time-lapse slider sequencer core.
// ----------------------------------------------------------------------------
// A scoreboard class carries its own model of the run and step sequencing, so
// every accepted poll item produces one predicted status item, which the
// monitor checks field by field against the status stream. The run starts with
// a short directed list (homing, the end switch, stops, time wrap), then goes
// through several register settings with random but mostly sensible polls and
// changing back-pressure.
// ----------------------------------------------------------------------------
module timelapse_slider_sequencer_core_tb;
   import tss_pkg::*;

   localparam int unsigned SPEED_SCALE = 100;

   typedef struct packed {
      logic [COUNT_W-1:0] photos_done;
      run_mode_type       run_mode;
      logic [LED2_W-1:0]  led2_mode;
      logic               led1_mode;
      logic               shutter_on;
      logic               motor_dir;
      logic [POWER_W-1:0] motor_power;
   } status_type;

   class slider_scoreboard;
      logic [NOW_W-1:0]   move_span;
      logic [NOW_W-1:0]   exposure_ms;
      logic [COUNT_W-1:0] photo_total;
      logic               fwd_dir;
      run_mode_type       mode;
      step_type           step;
      logic [NOW_W-1:0]   mark;
      logic [COUNT_W-1:0] photos;
      logic [POWER_W-1:0] power;
      logic               dir;
      logic               shutter;
      logic               led1;
      logic [LED2_W-1:0]  led2;
      status_type         expected_status[$];
      int                 errors;

      function new();
         move_span = '0;
         exposure_ms = '0;
         photo_total = '0;
         fwd_dir = 1'b0;
         mode = RM_IDLE;
         step = ST_IDLE;
         mark = '0;
         photos = '0;
         errors = 0;
         clear_outputs();
         led1 = 1'b1;
      endfunction

      function void clear_outputs();
         led1 = 1'b0;
         led2 = LED2_OFF;
         shutter = 1'b0;
         dir = fwd_dir;
         power = POWER_OFF;
      endfunction

      function bit elapsed(logic [NOW_W-1:0] now, logic [NOW_W-1:0] span);
         logic [NOW_W-1:0] diff;
         diff = now - mark;
         return diff > span;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_MOVE_SPEED:  move_span = {16'd0, value[15:0]} * SPEED_SCALE;
            CSR_EXPOSURE:    exposure_ms = value;
            CSR_TOTAL:       photo_total = value[COUNT_W-1:0];
            CSR_FORWARD_DIR: fwd_dir = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      function void predict_poll(poll_type p);
         status_type s;
         if (p.op != OP_NONE) mode = run_mode_type'({1'b0, p.op});
         if (p.emergency_stop) mode = RM_STOP;
         case (mode)
            RM_START: begin
               clear_outputs();
               photos = '0;
               mode = RM_RUNNING;
               step = ST_IDLE;
            end
            RM_STOP: begin
               clear_outputs();
               mode = RM_IDLE;
               led1 = 1'b1;
               step = ST_IDLE;
            end
            RM_HOME_REQ: begin
               clear_outputs();
               mode = RM_HOMING;
               step = ST_IDLE;
            end
            RM_RUNNING: begin
               if (p.at_end) begin
                  mode = RM_STOP;
               end else begin
                  case (step)
                     ST_IDLE: step = ST_FORWARD;
                     ST_FORWARD: if (elapsed(p.now_ms, move_span)) begin
                        mark = p.now_ms;
                        power = POWER_OFF;
                        led2 = LED2_OFF;
                        step = ST_SETTLE;
                     end
                     ST_SETTLE: if (elapsed(p.now_ms, SETTLE_MS)) begin
                        mark = p.now_ms;
                        shutter = 1'b1;
                        step = ST_SHOOT;
                     end
                     ST_SHOOT: if (elapsed(p.now_ms, SHOOT_MS)) begin
                        mark = p.now_ms;
                        shutter = 1'b0;
                        photos = photos + 1'b1;
                        step = ST_WAIT;
                     end
                     ST_WAIT: if (elapsed(p.now_ms, exposure_ms)) begin
                        mark = p.now_ms;
                        power = POWER_CREEP;
                        led2 = LED2_ON;
                        step = ST_FORWARD;
                        if (photos == photo_total) mode = RM_STOP;
                     end
                     default: ;
                  endcase
               end
            end
            RM_HOMING: begin
               case (step)
                  ST_IDLE: begin
                     if (p.at_end) begin
                        mode = RM_STOP;
                     end else begin
                        led2 = LED2_BLINK;
                        dir = ~fwd_dir;
                        power = POWER_FAST;
                        step = ST_BACKWARD;
                     end
                  end
                  ST_BACKWARD: if (p.at_end) begin
                     power = POWER_OFF;
                     mark = p.now_ms;
                     step = ST_WAIT;
                  end
                  ST_WAIT: if (elapsed(p.now_ms, PAUSE_MS)) begin
                     dir = fwd_dir;
                     power = POWER_CREEP;
                     step = ST_FORWARD;
                  end
                  ST_FORWARD: if (!p.at_end) mode = RM_STOP;
                  default: ;
               endcase
            end
            default: ;
         endcase
         s.photos_done = photos;
         s.run_mode = mode;
         s.led2_mode = led2;
         s.led1_mode = led1;
         s.shutter_on = shutter;
         s.motor_dir = dir;
         s.motor_power = power;
         expected_status.push_back(s);
      endfunction

      function void check_status(logic [RSP_W-1:0] raw);
         status_type got;
         status_type want;
         string bad;
         got = raw;
         if (expected_status.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: status item %h arrived with none expected", raw);
            return;
         end
         want = expected_status.pop_front();
         bad = "";
         if (got.motor_power !== want.motor_power) bad = {bad, " motor_power"};
         if (got.motor_dir !== want.motor_dir) bad = {bad, " motor_dir"};
         if (got.shutter_on !== want.shutter_on) bad = {bad, " shutter_on"};
         if (got.led1_mode !== want.led1_mode) bad = {bad, " led1_mode"};
         if (got.led2_mode !== want.led2_mode) bad = {bad, " led2_mode"};
         if (got.run_mode !== want.run_mode) bad = {bad, " run_mode"};
         if (got.photos_done !== want.photos_done) bad = {bad, " photos_done"};
         if (bad != "") begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: status mismatch in%s: expected %h actual %h", bad, want, got);
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_wr_en = 1'b0;
   logic [CSR_A_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]   csr_wdata = '0;

   slider_scoreboard sb = new();
   int               send_idle_pct = 25;
   int               recv_idle_pct = 65;
   bit               stall_request = 1'b0;
   logic [NOW_W-1:0] poll_ms;

   timelapse_slider_sequencer_core #(.SPEED_SCALE(SPEED_SCALE)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("timelapse_slider_sequencer_core verification failed");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left = 400;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
   end

   task automatic send_poll(poll_type p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, p.at_end, p.emergency_stop, p.op, p.now_ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.predict_poll(p);
      @(negedge clock);
   endtask

   task automatic poll_item(logic [NOW_W-1:0] now, op_type op, logic estop, logic at_end);
      poll_type p;
      p.now_ms = now;
      p.op = op;
      p.emergency_stop = estop;
      p.at_end = at_end;
      send_poll(p);
   endtask

   task automatic load_settings(logic [15:0] speed, logic [31:0] exposure,
                                logic [15:0] total, logic fwd);
      csr_index_type    order [4];
      logic [CSR_W-1:0] vals [4];
      order = '{CSR_MOVE_SPEED, CSR_EXPOSURE, CSR_TOTAL, CSR_FORWARD_DIR};
      vals = '{{16'd0, speed}, exposure, {16'd0, total}, {31'd0, fwd}};
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(order[i], vals[i]);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(int items, bit with_pressure);
      int       r;
      poll_type p;
      logic     level;
      level = 1'b0;
      poll_ms = $urandom;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         p.op = OP_NONE;
         if (sb.mode == RM_IDLE) begin
            if (r < 12) p.op = OP_START;
            else if (r < 18) p.op = OP_HOME;
            else if (r < 20) p.op = OP_STOP;
         end else begin
            if (r < 2) p.op = OP_START;
            else if (r < 4) p.op = OP_STOP;
            else if (r < 6) p.op = OP_HOME;
         end
         p.emergency_stop = ($urandom_range(0, 199) == 0);
         if (level) level = ($urandom_range(0, 99) >= 15);
         else level = ($urandom_range(0, 99) < ((sb.mode == RM_HOMING) ? 15 : 2));
         p.at_end = ($urandom_range(0, 99) < 4) ? 1'($urandom_range(0, 1)) : level;
         r = $urandom_range(0, 99);
         if (r < 3) poll_ms = $urandom;
         else if (r < 8) poll_ms = poll_ms + $urandom_range(0, 8_000_000);
         else poll_ms = poll_ms + $urandom_range(0, 700);
         p.now_ms = poll_ms;
         send_poll(p);
         if (with_pressure && i == 60) stall_request = 1'b1;
      end
   endtask

   initial begin : stimulus
      logic [15:0] speeds [6];
      logic [31:0] waits [6];
      logic [15:0] totals [6];
      logic        dirs [6];
      speeds = '{16'd0, 16'd2, 16'd65535, 16'd1, 16'd5, 16'd0};
      waits  = '{32'd0, 32'd120, 32'hFFFF_FFFF, 32'd0, 32'd700, 32'd0};
      totals = '{16'd1, 16'd3, 16'd65535, 16'd0, 16'd5, 16'd0};
      dirs   = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      speeds[5] = 16'($urandom_range(0, 20));
      waits[5] = $urandom_range(0, 1500);
      totals[5] = 16'($urandom_range(0, 8));
      dirs[5] = 1'($urandom_range(0, 1));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_settings(16'd0, 32'd0, 16'd2, 1'b1);
      poll_item(32'd0, OP_NONE, 1'b0, 1'b0);
      poll_item(32'd5, OP_NONE, 1'b1, 1'b0);
      poll_item(32'd10, OP_HOME, 1'b0, 1'b0);
      poll_item(32'd20, OP_NONE, 1'b0, 1'b0);
      poll_item(32'd25, OP_HOME, 1'b0, 1'b0);
      poll_item(32'd30, OP_NONE, 1'b0, 1'b1);
      poll_item(32'd40, OP_HOME, 1'b0, 1'b0);
      poll_item(32'd50, OP_NONE, 1'b0, 1'b0);
      poll_item(32'd60, OP_NONE, 1'b0, 1'b1);
      poll_item(32'd360, OP_NONE, 1'b0, 1'b1);
      poll_item(32'd361, OP_NONE, 1'b0, 1'b0);
      poll_item(32'd370, OP_NONE, 1'b0, 1'b1);
      poll_item(32'd380, OP_NONE, 1'b0, 1'b0);
      poll_item(32'd390, OP_NONE, 1'b0, 1'b0);
      poll_item(32'hFFFF_FE00, OP_START, 1'b0, 1'b0);
      poll_item(32'hFFFF_FE01, OP_NONE, 1'b0, 1'b0);
      poll_item(32'hFFFF_FE02, OP_NONE, 1'b0, 1'b0);
      poll_item(32'hFFFF_FFFF, OP_NONE, 1'b0, 1'b0);
      poll_item(32'h0000_0030, OP_NONE, 1'b0, 1'b0);
      poll_item(32'h0000_0032, OP_NONE, 1'b0, 1'b0);
      poll_item(32'h0000_0032, OP_NONE, 1'b0, 1'b0);
      poll_item(32'h0000_0033, OP_NONE, 1'b0, 1'b0);
      poll_item(32'h0000_0040, OP_NONE, 1'b0, 1'b1);
      poll_item(32'h0000_0050, OP_NONE, 1'b0, 1'b0);
      poll_item(32'h0000_0060, OP_START, 1'b1, 1'b0);
      poll_item(32'h0000_0070, OP_STOP, 1'b0, 1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         load_settings(speeds[ph], waits[ph], totals[ph], dirs[ph]);
         case (ph / 2)
            0: begin send_idle_pct = 25; recv_idle_pct = 65; end
            1: begin send_idle_pct = 65; recv_idle_pct = 25; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         run_random(300, ph == 0);
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("timelapse_slider_sequencer_core verification clean");
      end else begin
         $display("timelapse_slider_sequencer_core verification failed");
      end
      $finish;
   end

endmodule
